### rtl/core/generational_handle_table_defines.svh
// ----------------------------------------------------------------------------
// Generational handle table assertion macros
// Shared assertion macros for the handle table checker.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define GHT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("handle table assertion failed");

// Assertion that is checked during reset as well.
`define GHT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("handle table assertion failed");

`endif

### rtl/core/ght_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared codes, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ght_pkg;

    localparam int SLOTS_DEFAULT = 256;

    localparam logic [31:0] GEN_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] GEN_FIRST = 32'd1;

    localparam logic [1:0] OP_EXPOSE = 2'd0;
    localparam logic [1:0] OP_INVALIDATE = 2'd1;
    localparam logic [1:0] OP_RESOLVE = 2'd2;

    localparam logic [2:0] STATUS_OK = 3'd0;
    localparam logic [2:0] STATUS_STALE_INDEX = 3'd1;
    localparam logic [2:0] STATUS_STALE_GEN = 3'd2;
    localparam logic [2:0] STATUS_NULL = 3'd3;
    localparam logic [2:0] STATUS_FULL = 3'd4;

    localparam logic [3:0] RES_NOP = 4'd0;
    localparam logic [3:0] RES_NULL = 4'd1;
    localparam logic [3:0] RES_FULL = 4'd2;
    localparam logic [3:0] RES_STALE_INDEX = 4'd3;
    localparam logic [3:0] RES_STALE_GEN = 4'd4;
    localparam logic [3:0] RES_EXPOSE_HIT = 4'd5;
    localparam logic [3:0] RES_APPEND = 4'd6;
    localparam logic [3:0] RES_INVALIDATE = 4'd7;
    localparam logic [3:0] RES_RESOLVE = 4'd8;

    typedef struct packed {
        logic       latch_in;
        logic       scan_start;
        logic       scan_step;
        logic       read_handle;
        logic       res_load;
        logic [3:0] res_sel;
        logic       out_load;
    } ght_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       obj_zero;
        logic       scan_more;
        logic       rd_valid;
        logic       slot_hit;
        logic       table_full;
        logic       idx_ok;
        logic       gen_ok;
        logic       out_free;
    } ght_stat_t;

endpackage

### rtl/core/generational_handle_table.sv
// ----------------------------------------------------------------------------
// Generational handle table
// Slot map that hands out index and generation handles for object words.
// ----------------------------------------------------------------------------
// One item enters on the s_ channel: s_tuser carries the operation (expose,
// invalidate or resolve) and s_tdata the object word and the handle. Each
// item gives exactly one item on the m_ channel, with the status in m_tuser
// and the handed-out index, generation and found object in m_tdata.
// The block works on one item at a time. Invalidate and resolve read the
// handle's slot and check its generation before the result is loaded; an
// out-of-range index, a null object or an unknown operation is answered
// from decode. Expose scans the slots in use for a free reusable slot, one
// slot per cycle through the slot memory read port, and appends a new slot
// (or reports full) if none is found. s_tready rises again once the result
// has moved into the output register. A new item is accepted while the
// previous result still waits in the output register; when the receiver
// stalls, the next result is held until the output register frees. Reset
// empties the table (no slot in use) and drops any pending result; the slot
// memories need no clearing.
// ----------------------------------------------------------------------------
module generational_handle_table #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,  // object_value, handle_index, handle_generation
    input  logic [1:0]   s_tuser,  // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // out_index, out_generation, out_object
    output logic [2:0]   m_tuser   // status
);

    ght_pkg::ght_cmd_t  cmd;
    ght_pkg::ght_stat_t stat;

    ght_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ght_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/core/ght_ctrl.sv
// ----------------------------------------------------------------------------
// Generational handle table controller
// Sequences decode, slot scan, handle check and result hand-off.
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ght_pkg::ght_stat_t stat,
    output ght_pkg::ght_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.res_sel = ght_pkg::RES_NOP;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.op)
                    ght_pkg::OP_EXPOSE: begin
                        if (stat.obj_zero) begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel = ght_pkg::RES_NULL;
                            state_next = S_RESP;
                        end else begin
                            cmd.scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    ght_pkg::OP_INVALIDATE, ght_pkg::OP_RESOLVE: begin
                        if (stat.idx_ok) begin
                            cmd.read_handle = 1'b1;
                            state_next = S_CHECK;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel = ght_pkg::RES_STALE_INDEX;
                            state_next = S_RESP;
                        end
                    end
                    default: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel = ght_pkg::RES_NOP;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                if (stat.rd_valid && stat.slot_hit) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel = ght_pkg::RES_EXPOSE_HIT;
                    state_next = S_RESP;
                end else if (stat.scan_more) begin
                    cmd.scan_step = 1'b1;
                end else begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel = stat.table_full ? ght_pkg::RES_FULL : ght_pkg::RES_APPEND;
                    state_next = S_RESP;
                end
            end
            S_CHECK: begin
                cmd.res_load = 1'b1;
                if (!stat.gen_ok) begin
                    cmd.res_sel = ght_pkg::RES_STALE_GEN;
                end else if (stat.op == ght_pkg::OP_INVALIDATE) begin
                    cmd.res_sel = ght_pkg::RES_INVALIDATE;
                end else begin
                    cmd.res_sel = ght_pkg::RES_RESOLVE;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/ght_datapath.sv
// ----------------------------------------------------------------------------
// Generational handle table datapath
// Slot memories, slot count, scan pointer, result and output registers.
// ----------------------------------------------------------------------------
module ght_datapath #(
    parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [127:0]       s_tdata,
    input  logic [1:0]         s_tuser,
    input  ght_pkg::ght_cmd_t  cmd,
    output ght_pkg::ght_stat_t stat,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [127:0]       m_tdata,
    output logic [2:0]         m_tuser
);

    localparam int AW = $clog2(SLOTS);
    localparam int UW = $clog2(SLOTS + 1);

    logic [63:0] obj_mem [SLOTS];
    logic [31:0] gen_mem [SLOTS];

    logic [1:0]    op_reg;
    logic [63:0]   obj_reg;
    logic [31:0]   idx_reg;
    logic [31:0]   gen_reg;
    logic [UW-1:0] slots_used_reg;
    logic [UW-1:0] scan_addr_reg;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [63:0]   rd_obj_reg;
    logic [31:0]   rd_gen_reg;

    logic [2:0]  res_status_reg;
    logic [31:0] res_index_reg;
    logic [31:0] res_gen_reg;
    logic [63:0] res_obj_reg;
    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [127:0] m_data_reg;

    logic          rd_en;
    logic [AW-1:0] rd_addr_next;
    logic          we_obj;
    logic          we_gen;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_obj;
    logic [31:0]   wr_gen;
    logic [2:0]    res_status_next;
    logic [31:0]   res_index_next;
    logic [31:0]   res_gen_next;
    logic [63:0]   res_obj_next;
    logic          append;

    assign stat.op = op_reg;
    assign stat.obj_zero = (obj_reg == 64'd0);
    assign stat.scan_more = (scan_addr_reg < slots_used_reg);
    assign stat.rd_valid = rd_valid_reg;
    assign stat.slot_hit = (rd_obj_reg == 64'd0) && (rd_gen_reg != ght_pkg::GEN_MAX);
    assign stat.table_full = (slots_used_reg == UW'(SLOTS));
    assign stat.idx_ok = (idx_reg < 32'(slots_used_reg));
    assign stat.gen_ok = (rd_obj_reg != 64'd0) && (rd_gen_reg == gen_reg);
    assign stat.out_free = !m_valid_reg || m_tready;

    assign rd_en = cmd.scan_step || cmd.read_handle;
    assign rd_addr_next = cmd.read_handle ? idx_reg[AW-1:0] : scan_addr_reg[AW-1:0];
    assign append = cmd.res_load && (cmd.res_sel == ght_pkg::RES_APPEND);

    always_comb begin
        we_obj = 1'b0;
        we_gen = 1'b0;
        wr_addr = rd_addr_reg;
        wr_obj = obj_reg;
        wr_gen = rd_gen_reg;
        res_status_next = ght_pkg::STATUS_OK;
        res_index_next = 32'd0;
        res_gen_next = 32'd0;
        res_obj_next = 64'd0;
        case (cmd.res_sel)
            ght_pkg::RES_NULL: begin
                res_status_next = ght_pkg::STATUS_NULL;
            end
            ght_pkg::RES_FULL: begin
                res_status_next = ght_pkg::STATUS_FULL;
            end
            ght_pkg::RES_STALE_INDEX: begin
                res_status_next = ght_pkg::STATUS_STALE_INDEX;
            end
            ght_pkg::RES_STALE_GEN: begin
                res_status_next = ght_pkg::STATUS_STALE_GEN;
            end
            ght_pkg::RES_EXPOSE_HIT: begin
                we_obj = cmd.res_load;
                res_index_next = 32'(rd_addr_reg);
                res_gen_next = rd_gen_reg;
            end
            ght_pkg::RES_APPEND: begin
                we_obj = cmd.res_load;
                we_gen = cmd.res_load;
                wr_addr = slots_used_reg[AW-1:0];
                wr_gen = ght_pkg::GEN_FIRST;
                res_index_next = 32'(slots_used_reg);
                res_gen_next = ght_pkg::GEN_FIRST;
            end
            ght_pkg::RES_INVALIDATE: begin
                we_obj = cmd.res_load;
                we_gen = cmd.res_load;
                wr_obj = 64'd0;
                wr_gen = (rd_gen_reg == ght_pkg::GEN_MAX) ? rd_gen_reg : rd_gen_reg + 32'd1;
            end
            ght_pkg::RES_RESOLVE: begin
                res_obj_next = rd_obj_reg;
            end
            default: begin
                res_status_next = ght_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we_obj) begin
            obj_mem[wr_addr] <= wr_obj;
        end
        if (we_gen) begin
            gen_mem[wr_addr] <= wr_gen;
        end
        if (rd_en) begin
            rd_obj_reg <= obj_mem[rd_addr_next];
            rd_gen_reg <= gen_mem[rd_addr_next];
            rd_addr_reg <= rd_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg <= s_tuser;
            obj_reg <= s_tdata[63:0];
            idx_reg <= s_tdata[95:64];
            gen_reg <= s_tdata[127:96];
        end
        if (cmd.scan_start) begin
            scan_addr_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_addr_reg <= scan_addr_reg + UW'(1);
        end
        if (cmd.res_load) begin
            res_status_reg <= res_status_next;
            res_index_reg <= res_index_next;
            res_gen_reg <= res_gen_next;
            res_obj_reg <= res_obj_next;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_data_reg <= {res_obj_reg, res_gen_reg, res_index_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_used_reg <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (append) begin
                slots_used_reg <= slots_used_reg + UW'(1);
            end
            if (cmd.scan_start) begin
                rd_valid_reg <= 1'b0;
            end else if (cmd.scan_step) begin
                rd_valid_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_status_reg;

endmodule

### rtl/core/ght_checker.sv
// ----------------------------------------------------------------------------
// Generational handle table checker
// Port-level assertions on the handle table, bound to the top level.
// ----------------------------------------------------------------------------
`include "generational_handle_table_defines.svh"

module ght_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [2:0]   m_tuser
);

    `GHT_ASSERT(a_busy_after_accept, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    `GHT_ASSERT(a_result_held, aclk, aresetn, (m_tvalid && !m_tready) |=> m_tvalid)
    `GHT_ASSERT(a_error_no_data, aclk, aresetn, (m_tvalid && (m_tuser != ght_pkg::STATUS_OK)) |-> (m_tdata == 128'd0))
    `GHT_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule

bind generational_handle_table ght_checker u_ght_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
